// ===== rtl/core/cbtc_pkg.sv =====
// ----------------------------------------------------------------------------
// cbtc_pkg
// shared types and constants for the cubic bezier timing curve block
// ----------------------------------------------------------------------------
package cbtc_pkg;

	localparam int CFG_W = 19;
	localparam int IN_W  = 18;
	localparam int OUT_W = 19;
	localparam int IDX_W = 2;

	// register indexes
	localparam logic [IDX_W-1:0] REG_CTRL1_X = 2'd0;
	localparam logic [IDX_W-1:0] REG_CTRL1_Y = 2'd1;
	localparam logic [IDX_W-1:0] REG_CTRL2_X = 2'd2;
	localparam logic [IDX_W-1:0] REG_CTRL2_Y = 2'd3;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,      // latch t and coefficients, u = t
		OP_POLY_X,    // start cubic x(u)
		OP_DERIV,     // start derivative x'(u)
		OP_DIV,       // start newton divide
		OP_UPDATE,    // u -= quotient, saturate
		OP_CLAMP,     // clamp u to 0..one
		OP_BIS_INIT,  // lo = 0, hi = one
		OP_BIS_MID,   // u = midpoint, start x(u)
		OP_BIS_STEP,  // narrow interval
		OP_POLY_Y,    // start cubic y(u)
		OP_OUT        // load result register
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic busy;       // multi-cycle unit running
		logic t_low;      // t <= 0
		logic t_high;     // t >= one
		logic diff_small; // |x(u) - t| <= 1
		logic der_small;  // |x'(u)| <= 1
		logic bis_done;   // hi - lo <= 1
	} dp_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_NX,
		ST_NX_W,
		ST_ND,
		ST_ND_W,
		ST_NDIV_W,
		ST_CLAMP,
		ST_CHK_W,
		ST_BIS_MID,
		ST_BIS_W,
		ST_Y_W,
		ST_OUT
	} ctl_state_t;

endpackage

// ===== rtl/core/cbtc_div.sv =====
// ----------------------------------------------------------------------------
// cbtc_div
// restoring signed divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
module cbtc_div #(
	parameter int NUM_W = 64,
	parameter int DEN_W = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] num,
	input  logic signed [DEN_W-1:0] den,
	output logic                    busy,
	output logic signed [NUM_W-1:0] quo
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] q_q;
	logic [NUM_W-1:0] r_q;
	logic [DEN_W-1:0] d_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W:0]   trial;

	assign trial = {r_q, q_q[NUM_W-1]} - {{(NUM_W+1-DEN_W){1'b0}}, d_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(NUM_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// shift and subtract
	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num[NUM_W-1] ? NUM_W'(-num) : num;
			d_q   <= den[DEN_W-1] ? DEN_W'(-den) : den;
			r_q   <= '0;
			neg_q <= num[NUM_W-1] ^ den[DEN_W-1];
		end else if (cnt_q != '0) begin
			if (!trial[NUM_W]) begin
				r_q <= trial[NUM_W-1:0];
				q_q <= {q_q[NUM_W-2:0], 1'b1};
			end else begin
				r_q <= {r_q[NUM_W-2:0], q_q[NUM_W-1]};
				q_q <= {q_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quo  = neg_q ? NUM_W'(-q_q) : q_q;
endmodule

// ===== rtl/core/cbtc_ctrl.sv =====
// ----------------------------------------------------------------------------
// cbtc_ctrl
// sequencer: newton iterations, bisection fallback, final y evaluation
// ----------------------------------------------------------------------------
module cbtc_ctrl #(
	parameter int NEWTON_STEPS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_go,
	input  logic               out_free,
	input  cbtc_pkg::dp_stat_t stat,
	output cbtc_pkg::dp_cmd_t  cmd,
	output logic               idle
);
	import cbtc_pkg::*;

	localparam int IT_W = $clog2(NEWTON_STEPS + 1) + 1;

	ctl_state_t      state_q, state_d;
	logic [IT_W-1:0] it_q, it_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			it_q    <= '0;
		end else begin
			state_q <= state_d;
			it_q    <= it_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		it_d    = it_q;
		cmd.op  = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (in_go) begin
					cmd.op  = OP_LOAD;
					it_d    = '0;
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (stat.t_low || stat.t_high) state_d = ST_OUT;
				else state_d = ST_NX;
			end
			ST_NX: begin
				if (it_q >= IT_W'(NEWTON_STEPS)) begin
					state_d = ST_CLAMP;
				end else begin
					cmd.op  = OP_POLY_X;
					state_d = ST_NX_W;
				end
			end
			ST_NX_W: begin
				if (!stat.busy) begin
					if (stat.diff_small) state_d = ST_CLAMP;
					else state_d = ST_ND;
				end
			end
			ST_ND: begin
				cmd.op  = OP_DERIV;
				state_d = ST_ND_W;
			end
			ST_ND_W: begin
				if (!stat.busy) begin
					if (stat.der_small) begin
						state_d = ST_CLAMP;
					end else begin
						cmd.op  = OP_DIV;
						state_d = ST_NDIV_W;
					end
				end
			end
			ST_NDIV_W: begin
				if (!stat.busy) begin
					cmd.op  = OP_UPDATE;
					it_d    = it_q + 1'b1;
					state_d = ST_NX;
				end
			end
			ST_CLAMP: begin
				cmd.op  = OP_CLAMP;
				state_d = ST_CHK_W;
			end
			ST_CHK_W: begin
				// check after clamp: x(u) started by clamp op
				if (!stat.busy) begin
					if (stat.diff_small) begin
						cmd.op  = OP_POLY_Y;
						state_d = ST_Y_W;
					end else begin
						cmd.op  = OP_BIS_INIT;
						state_d = ST_BIS_MID;
					end
				end
			end
			ST_BIS_MID: begin
				if (stat.bis_done) begin
					cmd.op  = OP_POLY_Y;
					state_d = ST_Y_W;
				end else begin
					cmd.op  = OP_BIS_MID;
					state_d = ST_BIS_W;
				end
			end
			ST_BIS_W: begin
				if (!stat.busy) begin
					cmd.op  = OP_BIS_STEP;
					state_d = ST_BIS_MID;
				end
			end
			ST_Y_W: begin
				if (!stat.busy) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.op  = OP_OUT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign idle = (state_q == ST_IDLE);

	// newton count never passes its limit
	a_it_bound: assert property (@(posedge clk) disable iff (!arst_n)
		it_q <= IT_W'(NEWTON_STEPS))
		else $error("newton count overrun");
	// a new item only starts from idle
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_LOAD |-> state_q == ST_IDLE)
		else $error("load outside idle");
	// output load leaves for idle
	a_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_OUT |=> state_q == ST_IDLE)
		else $error("output did not return to idle");
endmodule

// ===== rtl/core/cbtc_dp.sv =====
// ----------------------------------------------------------------------------
// cbtc_dp
// datapath: coefficients, shared multiplier for horner steps, divider,
// newton and bisection registers, result register
// ----------------------------------------------------------------------------
module cbtc_dp #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cbtc_pkg::dp_cmd_t                 cmd,
	input  logic signed [cbtc_pkg::IN_W-1:0]  t_in,
	input  logic signed [cbtc_pkg::CFG_W-1:0] c1x,
	input  logic signed [cbtc_pkg::CFG_W-1:0] c1y,
	input  logic signed [cbtc_pkg::CFG_W-1:0] c2x,
	input  logic signed [cbtc_pkg::CFG_W-1:0] c2y,
	output cbtc_pkg::dp_stat_t                stat,
	output logic signed [cbtc_pkg::OUT_W-1:0] y_out
);
	import cbtc_pkg::*;

	localparam int V_W   = 24 + FRAC_BITS;       // values incl. coefficients
	// multiplier operands: horner partials stay under 128 ones or the y span,
	// u stays within +-2 ones
	localparam int MA_W  = (FRAC_BITS + 8 > CFG_W + 6) ? FRAC_BITS + 8 : CFG_W + 6;
	localparam int U_W   = FRAC_BITS + 3;
	localparam int P_W   = MA_W + U_W;
	localparam int NUM_W = V_W + FRAC_BITS + 2;
	localparam logic signed [V_W-1:0] ONE  = V_W'(1) <<< FRAC_BITS;
	localparam logic signed [P_W-1:0] HALF = P_W'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [V_W-1:0] TWO  = ONE <<< 1;
	localparam logic signed [V_W-1:0] OMAX = V_W'((1 << (OUT_W - 1)) - 1);
	localparam logic signed [V_W-1:0] OMIN = -V_W'(1 << (OUT_W - 1));

	logic signed [V_W-1:0] t_q, u_q, lo_q, hi_q, diff_q, der_q;
	logic signed [V_W-1:0] a_q, b_q, c_q, acc_q, m_a_q;
	logic [1:0]            step_q;
	logic                  mode_q;    // 0: polynomial, 1: derivative
	logic                  bis_q;     // result feeds bisection compare
	logic signed [V_W-1:0] sx1, sx2, x1, x2, xy1, xy2;
	logic signed [MA_W-1:0] m_op;
	logic signed [U_W-1:0]  u_op;
	logic signed [P_W-1:0] prod, prod_r;
	logic signed [V_W-1:0] rnd;
	logic signed [V_W-1:0] cx, bx, ax, cy, by, ay, nu, mid;
	logic                  div_busy;
	logic signed [NUM_W-1:0] quo;
	logic                  xless_q;
	logic signed [V_W-1:0] dabs, qabs;

	// clamp x control points and build coefficients
	assign sx1 = V_W'(c1x);
	assign sx2 = V_W'(c2x);
	assign x1  = sx1 < 0 ? '0 : (sx1 > ONE ? ONE : sx1);
	assign x2  = sx2 < 0 ? '0 : (sx2 > ONE ? ONE : sx2);
	assign xy1 = V_W'(c1y);
	assign xy2 = V_W'(c2y);
	assign cx  = 3 * x1;
	assign bx  = 3 * (x2 - x1) - cx;
	assign ax  = ONE - cx - bx;
	assign cy  = 3 * xy1;
	assign by  = 3 * (xy2 - xy1) - cy;
	assign ay  = ONE - cy - by;

	// one multiply per cycle, rounded half up
	assign m_op   = m_a_q[MA_W-1:0];
	assign u_op   = u_q[U_W-1:0];
	assign prod   = m_op * u_op;
	assign prod_r = prod + HALF;
	assign rnd    = V_W'(prod_r >>> FRAC_BITS);
	assign mid    = V_W'((lo_q + hi_q) >>> 1);
	assign nu     = u_q - V_W'(quo);
	assign dabs   = diff_q < 0 ? -diff_q : diff_q;
	assign qabs   = der_q < 0 ? -der_q : der_q;

	cbtc_div #(.NUM_W(NUM_W), .DEN_W(V_W)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.op == OP_DIV),
		.num   (NUM_W'(diff_q) <<< FRAC_BITS),
		.den   (der_q),
		.busy  (div_busy),
		.quo   (quo)
	);

	// horner step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) step_q <= '0;
		else if (cmd.op == OP_POLY_X || cmd.op == OP_BIS_MID || cmd.op == OP_POLY_Y
			|| cmd.op == OP_CLAMP) step_q <= 2'd3;
		else if (cmd.op == OP_DERIV) step_q <= 2'd2;
		else if (step_q != '0) step_q <= step_q - 1'b1;
	end

	// registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				t_q <= V_W'(t_in);
				u_q <= V_W'(t_in);
				a_q <= ax; b_q <= bx; c_q <= cx;
			end
			OP_POLY_X, OP_POLY_Y, OP_CLAMP, OP_BIS_MID: begin
				mode_q <= 1'b0;
				bis_q  <= (cmd.op == OP_BIS_MID);
				if (cmd.op == OP_POLY_Y) begin
					a_q <= ay; b_q <= by; c_q <= cy; m_a_q <= ay;
				end else begin
					m_a_q <= a_q;
				end
				if (cmd.op == OP_CLAMP)
					u_q <= u_q < 0 ? '0 : (u_q > ONE ? ONE : u_q);
				if (cmd.op == OP_BIS_MID) u_q <= mid;
			end
			OP_DERIV: begin
				mode_q <= 1'b1;
				m_a_q  <= 3 * a_q;
			end
			OP_UPDATE: u_q <= nu < -TWO ? -TWO : (nu > TWO ? TWO : nu);
			OP_BIS_INIT: begin
				lo_q <= '0;
				hi_q <= ONE;
			end
			OP_BIS_STEP: begin
				if (xless_q) lo_q <= u_q;
				else hi_q <= u_q;
			end
			OP_OUT: begin
				if (t_q <= 0) y_out <= '0;
				else if (t_q >= ONE) y_out <= OUT_W'(ONE > OMAX ? OMAX : ONE);
				else y_out <= OUT_W'(acc_q < OMIN ? OMIN : (acc_q > OMAX ? OMAX : acc_q));
			end
			default: ;
		endcase
		// horner progression
		if (step_q != '0) begin
			if (!mode_q) begin
				if (step_q == 2'd3) m_a_q <= rnd + b_q;
				else if (step_q == 2'd2) m_a_q <= rnd + c_q;
				else begin
					acc_q   <= rnd;
					diff_q  <= rnd - t_q;
					xless_q <= rnd < t_q;
				end
			end else begin
				if (step_q == 2'd2) m_a_q <= rnd + (b_q <<< 1);
				else der_q <= rnd + c_q;
			end
		end
	end

	assign stat.busy       = (step_q != '0) || div_busy;
	assign stat.t_low      = (t_q <= 0);
	assign stat.t_high     = (t_q >= ONE);
	assign stat.diff_small = (dabs <= 1);
	assign stat.der_small  = (qabs <= 1);
	assign stat.bis_done   = (hi_q - lo_q <= 1);
endmodule

// ===== rtl/core/cubic_bezier_timing_curve.sv =====
// ----------------------------------------------------------------------------
// cubic_bezier_timing_curve
// css style cubic bezier easing: maps time t to eased value y
// ----------------------------------------------------------------------------
// One item is worked at a time. Times at or outside 0..1 go straight from
// the load to the result load. Others run up to NEWTON_STEPS newton steps
// (horner x, the derivative and the bit-serial divider), then a check of
// the clamped u, a bisection of FRAC_BITS steps when newton missed, and
// y(u) with the result load; all horner steps share the single multiplier.
// The result waits in an output register, so a new item is accepted as
// soon as the sequencer is back in idle.
module cubic_bezier_timing_curve #(
	parameter int FRAC_BITS    = 16,
	parameter int NEWTON_STEPS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [17:0] time_in
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [18:0] eased_value
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [18:0] cfg_data
);
	import cbtc_pkg::*;

	logic signed [CFG_W-1:0] c1x_q, c1y_q, c2x_q, c2y_q;
	logic signed [OUT_W-1:0] y;
	dp_cmd_t                 cmd;
	dp_stat_t                stat;
	logic                    idle, vld_q;

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1x_q <= 19'sd16384;
			c1y_q <= '0;
			c2x_q <= 19'sd49152;
			c2y_q <= 19'sd65536;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_CTRL1_X: c1x_q <= cfg_data;
				REG_CTRL1_Y: c1y_q <= cfg_data;
				REG_CTRL2_X: c2x_q <= cfg_data;
				REG_CTRL2_Y: c2y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_tready = idle;

	cbtc_ctrl #(.NEWTON_STEPS(NEWTON_STEPS)) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_go   (s_tvalid),
		.out_free(!vld_q || m_tready),
		.stat    (stat),
		.cmd     (cmd),
		.idle    (idle)
	);

	cbtc_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.t_in  (s_tdata[IN_W-1:0]),
		.c1x   (c1x_q),
		.c1y   (c1y_q),
		.c2x   (c2x_q),
		.c2y   (c2y_q),
		.stat  (stat),
		.y_out (y)
	);

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else if (cmd.op == OP_OUT) vld_q <= 1'b1;
		else if (m_tready) vld_q <= 1'b0;
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = {5'd0, y};

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && !m_tready |=> vld_q)
		else $error("result dropped");
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while busy");
	a_out_safe: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_OUT |-> (!vld_q || m_tready))
		else $error("result register overwritten");
endmodule
